>>> src/tqkv_pkg.sv
// Shared types and constants for the top-Q key/value tracker.
`timescale 1ns / 1ps

package tqkv_pkg;

  // Stream payload layout, fixed by the item fields
  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned S_TDATA_W = 64;
  localparam int unsigned M_TDATA_W = 64;

  // Quickselect sequencer status towards the control FSM
  typedef struct packed {
    logic busy;
    logic done;
  } tqkv_qstat_t;

endpackage

>>> src/top_q_key_value_tracker_top.sv
// Top level of the top-Q key/value tracker: insert path, maintenance control and query output.
//
//  channel | dir | tdata (low bit up)                | tuser | tlast
//  s_*     | in  | item_key[31:0], item_value[63:32] | mode  | -
//  m_*     | out | out_key[31:0], out_value[63:32]   | -     | last
//
// The insert that fills slot 0, and every query, starts the quickselect sequencer; each
// partition pass makes its pivot and final exchanges through the single-write-port store,
// and compares each key once, exchanging it where needed; the threshold is fetched at
// the end. A query then emits Q items.
// s_tready is low while either runs.
// Reset (rst, synchronous) clears the per-entry valid bits at once: no clearing pass.
// A stalled m_tready holds the output register; the next item can be taken meanwhile.
`timescale 1ns / 1ps

module top_q_key_value_tracker_top import tqkv_pkg::*; #(
  parameter int unsigned SLOTS      = 64,
  parameter int unsigned Q          = 32,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // item_key[31:0], item_value[63:32]
  input  logic                 s_tuser,   // mode: 0 insert, 1 query
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // out_key[31:0], out_value[63:32]
  output logic                 m_tlast
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned FW = $clog2(SLOTS + 1);
  localparam int unsigned EW = KEY_BITS + VALUE_BITS;
  localparam logic [AW-1:0] TGT  = AW'(SLOTS - Q);
  localparam logic [AW-1:0] TOPI = AW'(SLOTS - 1);

  typedef enum logic [1:0] {
    T_IDLE, T_MAINT, T_ERD, T_ELD
  } state_t;

  state_t              state;
  logic                query;
  logic [KEY_BITS-1:0] threshold;
  logic [FW-1:0]       free_index;
  logic [AW-1:0]       oidx;

  logic [KEY_BITS-1:0]   in_key;
  logic [VALUE_BITS-1:0] in_value;
  logic                  accept;
  logic                  ins_we;
  logic                  qs_start;
  tqkv_qstat_t           qs_stat;
  logic [KEY_BITS-1:0]   qs_thr;
  logic [AW-1:0]         qs_ra;
  logic [AW-1:0]         qs_rb;
  logic                  qs_we;
  logic [AW-1:0]         qs_wa;
  logic [EW-1:0]         qs_wd;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;
  logic [AW-1:0] mem_ra;
  logic [EW-1:0] rd_a;
  logic [EW-1:0] rd_b;
  logic          out_free;

  assign in_key   = KEY_BITS'(s_tdata[FIELD_W-1:0]);
  assign in_value = VALUE_BITS'(s_tdata[2*FIELD_W-1:FIELD_W]);

  assign s_tready = (state == T_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign ins_we   = accept && !s_tuser && (in_key >= threshold) && (free_index != '0);
  assign qs_start = (accept && s_tuser) || (ins_we && free_index == FW'(1));
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= T_IDLE;
      query      <= 1'b0;
      threshold  <= '0;
      free_index <= FW'(SLOTS);
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (ins_we) begin
            free_index <= free_index - FW'(1);
          end
          if (qs_start) begin
            query <= s_tuser;
            state <= T_MAINT;
          end
        end
        T_MAINT: begin
          if (qs_stat.done) begin
            threshold  <= qs_thr;
            free_index <= FW'(TGT);
            oidx       <= TGT;
            state      <= query ? T_ERD : T_IDLE;
          end
        end
        T_ERD: begin
          state <= T_ELD;
        end
        T_ELD: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {FIELD_W'(rd_a[EW-1:KEY_BITS]), FIELD_W'(rd_a[KEY_BITS-1:0])};
            m_tlast  <= (oidx == TOPI);
            if (oidx == TOPI) begin
              state <= T_IDLE;
            end else begin
              oidx  <= oidx + AW'(1);
              state <= T_ERD;
            end
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  // store port sharing: sequencer owns it during maintenance
  always_comb begin
    if (state == T_MAINT) begin
      mem_we = qs_we;
      mem_wa = qs_wa;
      mem_wd = qs_wd;
      mem_ra = qs_ra;
    end else begin
      mem_we = ins_we;
      mem_wa = AW'(free_index - FW'(1));
      mem_wd = {in_value, in_key};
      mem_ra = oidx;
    end
  end

  tqkv_store #(
    .DEPTH (SLOTS),
    .WIDTH (EW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .we      (mem_we),
    .waddr   (mem_wa),
    .wdata   (mem_wd),
    .raddr_a (mem_ra),
    .raddr_b (qs_rb),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  tqkv_qsel #(
    .SLOTS      (SLOTS),
    .Q          (Q),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_qsel (
    .clk    (clk),
    .rst    (rst),
    .start  (qs_start),
    .status (qs_stat),
    .thr    (qs_thr),
    .ra     (qs_ra),
    .rb     (qs_rb),
    .we     (qs_we),
    .wa     (qs_wa),
    .wd     (qs_wd),
    .rd_a   (rd_a),
    .rd_b   (rd_b)
  );

endmodule

>>> src/tqkv_store.sv
// Entry store: one write port, two registered read ports, per-entry valid bits.
`timescale 1ns / 1ps

module tqkv_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] qa;
  logic [WIDTH-1:0] qb;
  logic             va;
  logic             vb;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    qa <= mem[raddr_a];
    qb <= mem[raddr_b];
  end

  // an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      va    <= 1'b0;
      vb    <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      va <= valid[raddr_a];
      vb <= valid[raddr_b];
    end
  end

  assign rdata_a = va ? qa : '0;
  assign rdata_b = vb ? qb : '0;

endmodule

>>> src/tqkv_qsel.sv
// Quickselect sequencer: partitions the store one compare per step, then fetches the threshold.
`timescale 1ns / 1ps

module tqkv_qsel import tqkv_pkg::*; #(
  parameter int unsigned SLOTS      = 64,
  parameter int unsigned Q          = 32,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output tqkv_qstat_t                       status,
  output logic [KEY_BITS-1:0]               thr,
  output logic [$clog2(SLOTS)-1:0]          ra,
  output logic [$clog2(SLOTS)-1:0]          rb,
  output logic                              we,
  output logic [$clog2(SLOTS)-1:0]          wa,
  output logic [KEY_BITS+VALUE_BITS-1:0]    wd,
  input  logic [KEY_BITS+VALUE_BITS-1:0]    rd_a,
  input  logic [KEY_BITS+VALUE_BITS-1:0]    rd_b
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned EW = KEY_BITS + VALUE_BITS;
  localparam logic [AW-1:0] TGT  = AW'(SLOTS - Q);
  localparam logic [AW-1:0] TOPI = AW'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CAP, S_SW1, S_SW2, S_THR_RD, S_THR_CAP
  } state_t;

  // which part of a partition pass the current exchange belongs to
  typedef enum logic [1:0] {
    PH_PIVOT, PH_SCAN, PH_FINAL
  } phase_t;

  state_t            state;
  phase_t            phase;
  logic [AW-1:0]     lo;
  logic [AW-1:0]     hi;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     np;
  logic [AW-1:0]     addr_a;
  logic [AW-1:0]     addr_b;
  logic [EW-1:0]     da;
  logic [EW-1:0]     db;
  logic [KEY_BITS-1:0] pv;
  logic              done;
  logic              gt;
  logic [AW-1:0]     np_dec;

  // the one comparator of the sequencer
  assign gt     = rd_a[KEY_BITS-1:0] > pv;
  assign np_dec = np - AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_PIVOT;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            lo     <= '0;
            hi     <= TOPI;
            addr_a <= '0;
            addr_b <= TOPI;
            phase  <= PH_PIVOT;
            state  <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CAP;
        end
        S_CAP: begin
          da <= rd_a;
          db <= rd_b;
          unique case (phase)
            PH_PIVOT: begin
              pv    <= rd_a[KEY_BITS-1:0];
              state <= S_SW1;
            end
            PH_SCAN: begin
              if (gt) begin
                state <= S_SW1;
              end else if (idx == lo) begin
                phase  <= PH_FINAL;
                addr_a <= hi;
                addr_b <= np;
                state  <= S_RD;
              end else begin
                idx    <= idx - AW'(1);
                addr_a <= idx - AW'(1);
                addr_b <= np_dec;
                state  <= S_RD;
              end
            end
            default: begin
              state <= S_SW1;
            end
          endcase
        end
        S_SW1: begin
          state <= S_SW2;
        end
        S_SW2: begin
          unique case (phase)
            PH_PIVOT: begin
              np <= hi;
              if (hi > lo) begin
                idx    <= hi - AW'(1);
                addr_a <= hi - AW'(1);
                addr_b <= hi - AW'(1);
                phase  <= PH_SCAN;
              end else begin
                addr_a <= hi;
                addr_b <= hi;
                phase  <= PH_FINAL;
              end
              state <= S_RD;
            end
            PH_SCAN: begin
              np <= np_dec;
              if (idx == lo) begin
                phase  <= PH_FINAL;
                addr_a <= hi;
                addr_b <= np_dec;
              end else begin
                idx    <= idx - AW'(1);
                addr_a <= idx - AW'(1);
                addr_b <= np_dec - AW'(1);
              end
              state <= S_RD;
            end
            default: begin
              // pivot has landed at np
              if (np == TGT || (np > TGT && np == lo) || (np < TGT && np == hi)) begin
                addr_a <= TGT;
                state  <= S_THR_RD;
              end else if (np > TGT) begin
                hi     <= np_dec;
                addr_a <= lo;
                addr_b <= np_dec;
                phase  <= PH_PIVOT;
                state  <= S_RD;
              end else begin
                lo     <= np + AW'(1);
                addr_a <= np + AW'(1);
                addr_b <= hi;
                phase  <= PH_PIVOT;
                state  <= S_RD;
              end
            end
          endcase
        end
        S_THR_RD: begin
          state <= S_THR_CAP;
        end
        S_THR_CAP: begin
          thr   <= rd_a[KEY_BITS-1:0];
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // exchange: first write lands data of port a at addr_b, then port b data at addr_a
  assign ra = addr_a;
  assign rb = addr_b;
  assign we = (state == S_SW1) || (state == S_SW2);
  assign wa = (state == S_SW1) ? addr_b : addr_a;
  assign wd = (state == S_SW1) ? da : db;

  assign status.busy = (state != S_IDLE);
  assign status.done = done;

endmodule

>>> src/tqkv_checker.sv
// Port-level checks for the tracker top level, bound in below.
`timescale 1ns / 1ps

module tqkv_checker import tqkv_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tlast
);

  // a query always holds off the input side while maintenance runs
  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("input ready straight after a query");

  // mid-run items only appear while the input side is held off
  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input ready during a query run");

  // stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output item changed under stall");

  // nothing on the output straight out of reset
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind top_q_key_value_tracker_top tqkv_checker u_tqkv_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

>>> sim/tb.sv
// Self-checking testbench for the top-Q key/value tracker stream block.
`timescale 1ns / 1ps

module tb;
  import tqkv_pkg::*;

  localparam int SLOTS  = 64;
  localparam int Q      = 32;
  localparam int TARGET = SLOTS - Q;
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;
  localparam int RANDOM_ITEMS  = 500;
  localparam int SETTLE_CYCLES = 12000;  // worst-case quickselect after the last insert
  localparam int HOLD_CYCLES   = 400;

  typedef struct {
    logic [31:0] key;
    logic [31:0] value;
    logic        last;
  } top_entry_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;

  // mirror of the block's store
  logic [31:0] mirror_keys [SLOTS];
  logic [31:0] mirror_values [SLOTS];
  logic [31:0] mirror_threshold;
  int          mirror_free;

  top_entry_t pending_top_entries[$];
  int  mismatches;
  bit  tx_idle;
  bit  rx_idle;
  bit  long_hold_req;

  top_q_key_value_tracker_top #(
    .SLOTS(SLOTS), .Q(Q), .KEY_BITS(32), .VALUE_BITS(32)
  ) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic void swap_slots(input int a, input int b);
    logic [31:0] k;
    logic [31:0] v;
    k = mirror_keys[a];
    v = mirror_values[a];
    mirror_keys[a] = mirror_keys[b];
    mirror_values[a] = mirror_values[b];
    mirror_keys[b] = k;
    mirror_values[b] = v;
  endfunction

  // leftmost pivot; larger keys are gathered at the right end
  function automatic int partition_slots(input int lo, input int hi);
    logic [31:0] pivot;
    int np;
    pivot = mirror_keys[lo];
    np = hi;
    swap_slots(lo, hi);
    for (int i = hi - 1; i >= lo; i--) begin
      if (mirror_keys[i] > pivot) begin
        np--;
        swap_slots(i, np);
      end
    end
    swap_slots(hi, np);
    return np;
  endfunction

  function automatic void reselect_top();
    int lo;
    int hi;
    int p;
    bit found;
    lo = 0;
    hi = SLOTS - 1;
    found = 0;
    mirror_threshold = mirror_keys[TARGET];
    while (lo <= hi && !found) begin
      p = partition_slots(lo, hi);
      if (p == TARGET) begin
        found = 1;
      end else if (p > TARGET) begin
        hi = p - 1;
      end else begin
        lo = p + 1;
      end
      mirror_threshold = mirror_keys[TARGET];
    end
    mirror_free = TARGET;
  endfunction

  // returns 1 when the item changes state or yields entries
  function automatic bit apply_item(input logic mode, input logic [31:0] key,
                                    input logic [31:0] value);
    top_entry_t e;
    if (mode == MODE_QUERY) begin
      reselect_top();
      for (int i = TARGET; i < SLOTS; i++) begin
        e.key = mirror_keys[i];
        e.value = mirror_values[i];
        e.last = (i == SLOTS - 1);
        pending_top_entries.push_back(e);
      end
      return 1;
    end
    if (key < mirror_threshold || mirror_free == 0) return 0;
    mirror_free--;
    mirror_keys[mirror_free] = key;
    mirror_values[mirror_free] = value;
    if (mirror_free == 0) reselect_top();
    return 1;
  endfunction

  // leaves s_tvalid high on return so a back-to-back item needs no second assignment
  task automatic send_item(input logic mode, input logic [31:0] key,
                           input logic [31:0] value, output bit effective);
    int gap;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {value, key};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    effective = apply_item(mode, key, value);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_top_entries.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] draw_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5:       return $urandom_range(0, 15);
      6:          return mirror_threshold;
      7:          return mirror_threshold + $urandom_range(1, 3);
      8:          return mirror_threshold - 1;
      default:    return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  // result side: random stalls per item, plus an occasional long hold-off
  initial begin
    top_entry_t exp_e;
    int stall_left;
    stall_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
        if (pending_top_entries.size() == 0) begin
          report_mismatch($sformatf("unexpected item key %h value %h last %b",
                                    m_tdata[31:0], m_tdata[63:32], m_tlast));
        end else begin
          exp_e = pending_top_entries.pop_front();
          if (m_tdata[31:0] !== exp_e.key)
            report_mismatch($sformatf("out_key %h, expected %h", m_tdata[31:0], exp_e.key));
          if (m_tdata[63:32] !== exp_e.value)
            report_mismatch($sformatf("out_value %h, expected %h",
                                      m_tdata[63:32], exp_e.value));
          if (m_tlast !== exp_e.last)
            report_mismatch($sformatf("last %b, expected %b", m_tlast, exp_e.last));
        end
        stall_left = rx_idle ? $urandom_range(0, 5) : 0;
      end
      // the hold-off starts once a query's items are actually on the output
      if (long_hold_req && m_tvalid === 1'b1) begin
        stall_left = HOLD_CYCLES;
        long_hold_req = 0;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    bit eff;
    send_item(MODE_QUERY, 32'h0, 32'h0, eff);                 // store not yet full
    send_item(MODE_INSERT, 32'hFFFF_FFFF, 32'h0, eff);
    send_item(MODE_INSERT, 32'h0, 32'hFFFF_FFFF, eff);
    send_item(MODE_INSERT, 32'h8000_0001, 32'h5555_AAAA, eff);
    send_item(MODE_INSERT, 32'h7FFF_FFFF, 32'hAAAA_5555, eff);
    send_item(MODE_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, eff);
    send_item(MODE_INSERT, mirror_threshold, 32'h1234_5678, eff); // equal to threshold
    for (int i = 0; i < 6; i++)
      send_item(MODE_INSERT, 32'h100 + i, $urandom, eff);
    send_item(MODE_QUERY, 32'h0, 32'h0, eff);
    send_item(MODE_INSERT, mirror_threshold - 1, 32'hDEAD_BEEF, eff); // dropped if nonzero
    send_item(MODE_INSERT, mirror_threshold, 32'hCAFE_F00D, eff);
    send_item(MODE_QUERY, 32'h0, 32'h0, eff);
    wait_drained();
  endtask

  task automatic test_random_stream();
    bit eff;
    int done_items;
    logic mode;
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      // alternate stretches with and without idle cycles
      tx_idle = ((done_items / 100) % 3) != 1;
      rx_idle = ((done_items / 100) % 3) != 2;
      mode = ($urandom_range(0, 15) == 0) ? MODE_QUERY : MODE_INSERT;
      send_item(mode, draw_key(), $urandom, eff);
      done_items++;
    end
    tx_idle = 1;
    rx_idle = 1;
    wait_drained();
  endtask

  task automatic test_backpressure();
    bit eff;
    tx_idle = 0;
    long_hold_req = 1;
    send_item(MODE_QUERY, 32'h0, 32'h0, eff);
    send_item(MODE_QUERY, 32'h0, 32'h0, eff);
    for (int i = 0; i < 4; i++)
      send_item(MODE_INSERT, $urandom, $urandom, eff);
    send_item(MODE_QUERY, 32'h0, 32'h0, eff);
    tx_idle = 1;
  endtask

  task automatic test_pause_until_drained();
    bit eff;
    wait_drained();
    for (int i = 0; i < 40; i++)
      send_item(MODE_INSERT, $urandom, $urandom, eff);
    send_item(MODE_QUERY, 32'h0, 32'h0, eff);
  endtask

  initial begin
    mismatches = 0;
    tx_idle = 1;
    rx_idle = 1;
    long_hold_req = 0;
    for (int i = 0; i < SLOTS; i++) begin
      mirror_keys[i] = '0;
      mirror_values[i] = '0;
    end
    mirror_threshold = '0;
    mirror_free = SLOTS;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= MODE_INSERT;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_stream();
    test_backpressure();
    test_pause_until_drained();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
